/* src/aes128_pkg.sv */
// ----------------------------------------------------------------------------
// AES-128 package
// Shared payload types, register indexes, S-box functions and round helpers.
// ----------------------------------------------------------------------------
package aes128_pkg;

  localparam int unsigned NumRounds = 10;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_e;

  typedef enum logic {
    MODE_ENC = 1'b0,
    MODE_DEC = 1'b1
  } mode_e;

  typedef struct packed {
    logic        mode;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  localparam logic [7:0] FwdSbox [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] InvSbox [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  localparam logic [7:0] Rcon [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
  };

  // Byte n of a 128-bit word sits in bits 127-8n downto 120-8n.
  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [127:0] sbox_layer(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = inv ? InvSbox[s[127-8*i -: 8]] : FwdSbox[s[127-8*i -: 8]];
    end
    sbox_layer = r;
  endfunction

  function automatic logic [127:0] row_rotate(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        if (inv) begin
          r[127-8*(((c+w)%4)*4+w) -: 8] = s[127-8*(c*4+w) -: 8];
        end else begin
          r[127-8*(c*4+w) -: 8] = s[127-8*(((c+w)%4)*4+w) -: 8];
        end
      end
    end
    row_rotate = r;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0]   a [4];
    logic [7:0]   all;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) a[w] = s[127-8*(c*4+w) -: 8];
      all = a[0] ^ a[1] ^ a[2] ^ a[3];
      for (int w = 0; w < 4; w++) begin
        r[127-8*(c*4+w) -: 8] = a[w] ^ all ^ xtime(a[w] ^ a[(w+1)%4]);
      end
    end
    mix_cols = r;
  endfunction

  function automatic logic [127:0] unmix_cols(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0]   u;
    logic [7:0]   v;
    r = s;
    for (int c = 0; c < 4; c++) begin
      u = xtime(xtime(s[127-8*(c*4) -: 8] ^ s[127-8*(c*4+2) -: 8]));
      v = xtime(xtime(s[127-8*(c*4+1) -: 8] ^ s[127-8*(c*4+3) -: 8]));
      r[127-8*(c*4)   -: 8] = s[127-8*(c*4)   -: 8] ^ u;
      r[127-8*(c*4+1) -: 8] = s[127-8*(c*4+1) -: 8] ^ v;
      r[127-8*(c*4+2) -: 8] = s[127-8*(c*4+2) -: 8] ^ u;
      r[127-8*(c*4+3) -: 8] = s[127-8*(c*4+3) -: 8] ^ v;
    end
    unmix_cols = mix_cols(r);
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w [4];
    logic [31:0] t;
    for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
    t = {FwdSbox[w[3][23:16]] ^ rc, FwdSbox[w[3][15:8]],
         FwdSbox[w[3][7:0]], FwdSbox[w[3][31:24]]};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    next_key = {w[0], w[1], w[2], w[3]};
  endfunction

endpackage

/* src/aes128_block_cipher_core.sv */
// ----------------------------------------------------------------------------
// AES-128 block cipher core
// Fully unrolled encrypt/decrypt pipeline, one round per register stage.
// ----------------------------------------------------------------------------
// One block is accepted on any cycle with start_i high and busy_o low, and its
// result shows on res_o with res_valid_o for one cycle once it has passed every
// stage: one stage for the initial key add and one per round, ten rounds.
// Blocks can follow back to back while busy_o stays low, and the pipeline
// never stalls since the receiver takes every beat. The eleven round keys are
// expanded from the key registers into flops, one round key per cycle; busy_o
// stays high after reset and after every key write while that chain settles.
// Write keys only while no block is in flight.
module aes128_block_cipher_core
  import aes128_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  aes_in_t          blk_i,
  output logic             res_valid_o,
  output aes_out_t         res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_idx_i,
  input  logic [63:0]      cfg_data_i
);

  localparam int unsigned NumStages = NumRounds + 1;
  localparam logic [3:0]  SettleCycles = 4'(NumStages);

  logic [63:0]  key_hi_q, key_lo_q;
  logic [127:0] rk_q [NumStages];
  logic         valid_q [NumStages];
  logic         mode_q  [NumStages];
  logic [127:0] st_q    [NumStages];
  logic [127:0] st_d    [NumStages];
  logic         cfg_we;
  logic [3:0]   settle_q, settle_d;

  assign busy_o      = (settle_q != '0);
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_KEY_HIGH: key_hi_q <= cfg_data_i;
        REG_KEY_LOW:  key_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold off blocks until the new key has reached the last round key.
  always_comb begin
    settle_d = settle_q;
    if (cfg_we) begin
      settle_d = SettleCycles;
    end else if (settle_q != '0) begin
      settle_d = settle_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SettleCycles;
    end else begin
      settle_q <= settle_d;
    end
  end

  // Round key chain: each entry one key-expansion step after the one before.
  always_ff @(posedge clk_i) begin
    rk_q[0] <= {key_hi_q, key_lo_q};
    for (int r = 1; r < NumStages; r++) begin
      rk_q[r] <= next_key(rk_q[r-1], Rcon[r-1]);
    end
  end

  always_comb begin
    st_d[0] = {blk_i.block_high, blk_i.block_low} ^
              (blk_i.mode ? rk_q[NumRounds] : rk_q[0]);
    for (int r = 1; r < NumStages; r++) begin
      if (mode_q[r-1] == MODE_DEC) begin
        st_d[r] = sbox_layer(row_rotate(st_q[r-1], 1'b1), 1'b1) ^ rk_q[NumRounds-r];
        if (r != NumRounds) st_d[r] = unmix_cols(st_d[r]);
      end else begin
        st_d[r] = row_rotate(sbox_layer(st_q[r-1], 1'b0), 1'b0);
        if (r != NumRounds) st_d[r] = mix_cols(st_d[r]);
        st_d[r] = st_d[r] ^ rk_q[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumStages; r++) valid_q[r] <= 1'b0;
    end else begin
      valid_q[0] <= start_i & ~busy_o;
      for (int r = 1; r < NumStages; r++) valid_q[r] <= valid_q[r-1];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0]   <= st_d[0];
    mode_q[0] <= blk_i.mode;
    for (int r = 1; r < NumStages; r++) begin
      st_q[r]   <= st_d[r];
      mode_q[r] <= mode_q[r-1];
    end
  end

  assign res_valid_o = valid_q[NumRounds];
  assign res_o       = {st_q[NumRounds][127:64], st_q[NumRounds][63:0]};

endmodule

/* src/aes128_checker.sv */
// ----------------------------------------------------------------------------
// AES-128 port checker
// Latency and handshake properties seen at the core's ports.
// ----------------------------------------------------------------------------
module aes128_checker
  import aes128_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic res_valid_o,
  input logic cfg_valid_i,
  input logic cfg_ready_o
);

  a_key_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> busy_o)
    else $error("core not busy after key write");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##11 res_valid_o)
    else $error("result missing 11 cycles after start");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start_i && !busy_o, 11))
    else $error("result without matching start");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config beat stalled");

endmodule

bind aes128_block_cipher_core aes128_checker u_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .res_valid_o, .cfg_valid_i, .cfg_ready_o
);
